>>> sv/websocket_frame_deframer_defines.svh
// Assertion macros shared by the websocket deframer checker.
// Depends on nothing; included by the files that assert.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WSFD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("websocket deframer: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define WSFD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("websocket deframer: next-cycle check failed");

`endif

>>> sv/wsfd_pkg.sv
// Shared types, codes and helpers for the websocket frame deframer.
// Depends on nothing; used by every module of the block except the input register.
package wsfd_pkg;

   localparam int unsigned LENGTH_BITS_DEFAULT = 64;
   localparam int unsigned PLEN_WIDTH = 64;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_NO_MASK  = 2'd0;
   localparam logic [1:0] ERR_RSV      = 2'd1;
   localparam logic [1:0] ERR_CONTROL  = 2'd2;
   localparam logic [1:0] ERR_OPCODE   = 2'd3;

   // Opcodes.
   localparam logic [3:0] OPC_BINARY = 4'd2;
   localparam logic [3:0] OPC_CLOSE  = 4'd8;
   localparam logic [3:0] OPC_PING   = 4'd9;
   localparam logic [3:0] OPC_PONG   = 4'd10;

   // Seven-bit length field codes.
   localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
   localparam logic [6:0] LEN_EXT16    = 7'd126;
   localparam logic [6:0] LEN_EXT64    = 7'd127;

   // Byte counts of the extended length and of the mask key (counter wraps at 8).
   localparam logic [2:0] EXT16_BYTES = 3'd2;
   localparam logic [2:0] EXT64_BYTES = 3'd0;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   typedef struct packed {
      logic [1:0]            kind;
      logic [3:0]            frame_opcode;
      logic                  final_flag;
      logic [PLEN_WIDTH-1:0] payload_length;
      logic [7:0]            payload_byte;
      logic                  last_byte;
      logic [1:0]            error_code;
   } result_type;

   // Key byte for a payload position; the first key byte received is the top byte.
   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
      logic [7:0] kb;
      case (idx)
         2'd0:    kb = key[31:24];
         2'd1:    kb = key[23:16];
         2'd2:    kb = key[15:8];
         default: kb = key[7:0];
      endcase
      return kb;
   endfunction

endpackage

>>> sv/wsfd_in_stage.sv
// Input register of the websocket deframer: holds one received byte.
// Depends on nothing outside this file.
module wsfd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   output logic       req_stall,
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       load;

   // The register takes a new transaction whenever it is empty or being drained.
   assign load      = !valid_ff || advance;
   assign valid_in  = load ? req_valid : valid_ff;
   assign req_stall = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

>>> sv/wsfd_parser.sv
// Frame parser of the websocket deframer: header, length, key and payload state.
// Depends on wsfd_pkg.
module wsfd_parser #(
   parameter int unsigned LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   output logic                 res_valid,
   output wsfd_pkg::result_type res
);

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_KEY   = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [4:0]             foc_ff, foc_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [31:0]            key_ff, key_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   halted_ff, halted_in;

   logic [3:0] op;
   logic       fin;
   logic [6:0] len7;
   logic       is_ctrl;
   logic       err_hit;
   logic [1:0] err_code;
   logic [2:0] cnt_inc;
   logic       last;

   assign op      = foc_ff[3:0];
   assign fin     = foc_ff[4];
   assign len7    = rx_byte[6:0];
   assign cnt_inc = cnt_ff + 3'd1;
   assign last    = (rem_ff[LENGTH_BITS-1:1] == '0);
   assign is_ctrl = (op == wsfd_pkg::OPC_CLOSE) || (op == wsfd_pkg::OPC_PING) ||
                    (op == wsfd_pkg::OPC_PONG);

   // Second header byte checks, in order of precedence.
   always_comb begin
      err_hit  = 1'b1;
      err_code = wsfd_pkg::ERR_NO_MASK;
      if (!rx_byte[7]) begin
         err_code = wsfd_pkg::ERR_NO_MASK;
      end else if (cnt_ff != 3'd0) begin
         err_code = wsfd_pkg::ERR_RSV;
      end else if (is_ctrl && ((len7 > wsfd_pkg::LEN_CTRL_MAX) || !fin)) begin
         err_code = wsfd_pkg::ERR_CONTROL;
      end else if (!is_ctrl && (op > wsfd_pkg::OPC_BINARY)) begin
         err_code = wsfd_pkg::ERR_OPCODE;
      end else begin
         err_hit = 1'b0;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      foc_in    = foc_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      halted_in = halted_ff;

      res_valid          = 1'b0;
      res.kind           = wsfd_pkg::KIND_HEADER;
      res.frame_opcode   = foc_ff[3:0];
      res.final_flag     = foc_ff[4];
      res.payload_length = '0;
      res.payload_byte   = '0;
      res.last_byte      = 1'b0;
      res.error_code     = wsfd_pkg::ERR_NO_MASK;

      if (step && !halted_ff) begin
         unique case (phase_ff)
            PH_HDR0: begin
               foc_in   = {rx_byte[7], rx_byte[3:0]};
               cnt_in   = rx_byte[6:4];
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               if (err_hit) begin
                  halted_in      = 1'b1;
                  res_valid      = 1'b1;
                  res.kind       = wsfd_pkg::KIND_ERROR;
                  res.error_code = err_code;
               end else begin
                  cnt_in = 3'd0;
                  key_in = '0;
                  if (len7 == wsfd_pkg::LEN_EXT16) begin
                     acc_in   = '0;
                     phase_in = PH_EXT16;
                  end else if (len7 == wsfd_pkg::LEN_EXT64) begin
                     acc_in   = '0;
                     phase_in = PH_EXT64;
                  end else begin
                     acc_in   = LENGTH_BITS'(len7);
                     phase_in = PH_KEY;
                  end
               end
            end
            PH_EXT16, PH_EXT64: begin
               acc_in = {acc_ff[LENGTH_BITS-9:0], rx_byte};
               if (cnt_inc == ((phase_ff == PH_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                      : wsfd_pkg::EXT64_BYTES)) begin
                  cnt_in   = 3'd0;
                  phase_in = PH_KEY;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], rx_byte};
               if (cnt_inc < wsfd_pkg::KEY_BYTES) begin
                  cnt_in = cnt_inc;
               end else begin
                  cnt_in             = 3'd0;
                  idx_in             = 2'd0;
                  rem_in             = acc_ff;
                  phase_in           = (acc_ff == '0) ? PH_HDR0 : PH_DATA;
                  res_valid          = 1'b1;
                  res.payload_length = wsfd_pkg::PLEN_WIDTH'(acc_ff);
               end
            end
            PH_DATA: begin
               res_valid          = 1'b1;
               res.kind           = wsfd_pkg::KIND_PAYLOAD;
               res.payload_length = wsfd_pkg::PLEN_WIDTH'(acc_ff);
               res.payload_byte   = rx_byte ^ wsfd_pkg::key_byte(key_ff, idx_ff);
               res.last_byte      = last;
               idx_in             = idx_ff + 2'd1;
               rem_in             = last ? '0 : rem_ff - LENGTH_BITS'(1);
               if (last) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         foc_ff    <= '0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         key_ff    <= '0;
         rem_ff    <= '0;
         idx_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         foc_ff    <= foc_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         key_ff    <= key_in;
         rem_ff    <= rem_in;
         idx_ff    <= idx_in;
         halted_ff <= halted_in;
      end
   end

endmodule

>>> sv/wsfd_out_stage.sv
// Result register of the websocket deframer, driving the rsp_ channel.
// Depends on wsfd_pkg.
module wsfd_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  wsfd_pkg::result_type      res,
   output logic                      ready,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic [3:0]                rsp_frame_opcode,
   output logic                      rsp_final_flag,
   output logic [wsfd_pkg::PLEN_WIDTH-1:0] rsp_payload_length,
   output logic [7:0]                rsp_payload_byte,
   output logic                      rsp_last_byte,
   output logic [1:0]                rsp_error_code
);

   logic                 valid_ff, valid_in;
   wsfd_pkg::result_type res_ff;

   // The register can load when it is empty or its transaction leaves this cycle.
   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = ready ? push : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && push) begin
         res_ff <= res;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = res_ff.kind;
   assign rsp_frame_opcode   = res_ff.frame_opcode;
   assign rsp_final_flag     = res_ff.final_flag;
   assign rsp_payload_length = res_ff.payload_length;
   assign rsp_payload_byte   = res_ff.payload_byte;
   assign rsp_last_byte      = res_ff.last_byte;
   assign rsp_error_code     = res_ff.error_code;

endmodule

>>> sv/websocket_frame_deframer.sv
// WebSocket client-to-server deframer: takes one received byte per cycle and, after the
// mask key, reports the frame header, then each unmasked payload byte with the last one
// marked; a protocol error is reported once and the block then ignores all input until
// reset. A byte is accepted every cycle while rsp_stall is low; it is held in the input
// register while the parser updates its state in a single pass, and the result register
// then loads the result for rsp_. Bytes that cause no result still take their place in
// that pipeline. rsp_stall reaches req_stall within the same cycle once both registers
// hold a transaction.
// Depends on wsfd_pkg, wsfd_in_stage, wsfd_parser and wsfd_out_stage.
module websocket_frame_deframer #(
   parameter int unsigned LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [3:0]                      rsp_frame_opcode,
   output logic                            rsp_final_flag,
   output logic [wsfd_pkg::PLEN_WIDTH-1:0] rsp_payload_length,
   output logic [7:0]                      rsp_payload_byte,
   output logic                            rsp_last_byte,
   output logic [1:0]                      rsp_error_code
);

   logic                 item_valid;
   logic [7:0]           item_byte;
   logic                 out_ready;
   logic                 advance;
   logic                 res_valid;
   wsfd_pkg::result_type res;

   assign advance = item_valid && out_ready;

   wsfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .advance     (advance),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   wsfd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (item_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfd_out_stage u_out_stage (
      .clock              (clock),
      .reset              (reset),
      .push               (res_valid),
      .res                (res),
      .ready              (out_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_flag     (rsp_final_flag),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_error_code     (rsp_error_code)
   );

endmodule

>>> sv/wsfd_checker.sv
// Port-level checks for the websocket frame deframer, bound to its top level.
// Depends on wsfd_pkg and websocket_frame_deframer_defines.svh.
`include "websocket_frame_deframer_defines.svh"

module wsfd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [1:0]                      rsp_kind,
   input logic [wsfd_pkg::PLEN_WIDTH-1:0] rsp_payload_length,
   input logic [7:0]                      rsp_payload_byte,
   input logic                            rsp_last_byte,
   input logic [1:0]                      rsp_error_code
);

   logic seen_error_ff, seen_error_in;

   // Remembers that an error transaction has been delivered.
   assign seen_error_in = seen_error_ff ||
                          (rsp_valid && !rsp_stall && (rsp_kind == wsfd_pkg::KIND_ERROR));

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_error_ff <= 1'b0;
      end else begin
         seen_error_ff <= seen_error_in;
      end
   end

   `WSFD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_payload_byte) && $stable(rsp_error_code))

   `WSFD_ASSERT_IMP(a_silent_after_error, clock, reset, seen_error_ff, !rsp_valid)

   `WSFD_ASSERT_IMP(a_single_byte_is_last, clock, reset, rsp_valid && (rsp_kind == wsfd_pkg::KIND_PAYLOAD) && (rsp_payload_length == wsfd_pkg::PLEN_WIDTH'(1)), rsp_last_byte)

   `WSFD_ASSERT_IMP(a_error_fields_clear, clock, reset, rsp_valid && (rsp_kind == wsfd_pkg::KIND_ERROR), (rsp_payload_length == '0) && (rsp_payload_byte == '0) && !rsp_last_byte)

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (.*);

>>> test/tb_websocket_frame_deframer.sv
// Self-checking testbench for websocket_frame_deframer: streams masked client frames,
// predicts every header, payload and error transaction, and checks the rsp_ channel.
// Depends on wsfd_pkg and the websocket_frame_deframer RTL.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;

   localparam logic [3:0] OPC_CONT = 4'd0;
   localparam logic [3:0] OPC_TEXT = 4'd1;

   localparam int FORM_SHORT = 0;
   localparam int FORM_EXT16 = 1;
   localparam int FORM_EXT64 = 2;

   localparam int unsigned EXT16_LEN_BYTES = 2;
   localparam int unsigned EXT64_LEN_BYTES = 8;
   localparam int unsigned MASK_KEY_BYTES  = 4;

   localparam int unsigned RANDOM_BYTES = 700;
   localparam int unsigned HOLD_AFTER   = 200;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT  = 1200000;

   typedef enum logic [2:0] {
      SEEK_FLAGS,
      SEEK_LENGTH,
      TAKE_LEN16,
      TAKE_LEN64,
      TAKE_KEY,
      TAKE_PAYLOAD
   } parse_phase_type;

   typedef struct {
      logic [7:0] value;
      bit         drain;
   } stream_item_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [7:0]                      req_rx_byte;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [1:0]                      rsp_kind;
   logic [3:0]                      rsp_frame_opcode;
   logic                            rsp_final_flag;
   logic [wsfd_pkg::PLEN_WIDTH-1:0] rsp_payload_length;
   logic [7:0]                      rsp_payload_byte;
   logic                            rsp_last_byte;
   logic [1:0]                      rsp_error_code;

   websocket_frame_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_flag     (rsp_final_flag),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_error_code     (rsp_error_code)
   );

   stream_item_type      stream_bytes[$];
   wsfd_pkg::result_type parsed_results[$];
   bit                   drain_next;

   // Parser state mirrored on the testbench side.
   parse_phase_type phase_q;
   logic            fin_cur;
   logic [3:0]      opcode_cur;
   logic [2:0]      rsv_bits;
   logic [63:0]     frame_len;
   int unsigned     taken;
   logic [31:0]     mask_word;
   logic [63:0]     bytes_left;
   logic [1:0]      key_pos;
   bit              stopped;

   int unsigned          cycle_count;
   int unsigned          bytes_sent;
   int unsigned          results_seen;
   int unsigned          headers_seen;
   int unsigned          payloads_seen;
   int unsigned          errors_seen;
   int unsigned          fail_count;
   int unsigned          send_gap;
   int unsigned          stall_left;
   int unsigned          hold_left;
   int unsigned          gap_draw;
   bit                   held;
   bit                   offering;
   bit                   produced;
   wsfd_pkg::result_type predicted;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, a few long ones, and regular stretches with none at all.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(99);
      if ((cycle_count % 1500) < 300) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic clear_parser();
      phase_q    = SEEK_FLAGS;
      fin_cur    = 1'b0;
      opcode_cur = '0;
      rsv_bits   = '0;
      frame_len  = '0;
      taken      = 0;
      mask_word  = '0;
      bytes_left = '0;
      key_pos    = '0;
      stopped    = 1'b0;
   endtask

   // Advances the mirrored parser by one byte; returns 1 when a result is due.
   function automatic bit parse_byte(input logic [7:0] b, output wsfd_pkg::result_type r);
      bit         emit;
      bit         bad;
      logic [1:0] code;
      logic [7:0] key;
      emit = 1'b0;
      bad  = 1'b0;
      code = wsfd_pkg::ERR_NO_MASK;
      r    = '0;
      if (!stopped) begin
         case (phase_q)
            SEEK_FLAGS: begin
               fin_cur    = b[7];
               opcode_cur = b[3:0];
               rsv_bits   = b[6:4];
               phase_q    = SEEK_LENGTH;
            end
            SEEK_LENGTH: begin
               if (!b[7]) begin
                  bad = 1'b1;
                  code = wsfd_pkg::ERR_NO_MASK;
               end else if (rsv_bits != 3'd0) begin
                  bad = 1'b1;
                  code = wsfd_pkg::ERR_RSV;
               end else if (opcode_cur == wsfd_pkg::OPC_CLOSE ||
                            opcode_cur == wsfd_pkg::OPC_PING ||
                            opcode_cur == wsfd_pkg::OPC_PONG) begin
                  if (b[6:0] > wsfd_pkg::LEN_CTRL_MAX || !fin_cur) begin
                     bad = 1'b1;
                     code = wsfd_pkg::ERR_CONTROL;
                  end
               end else if (opcode_cur > wsfd_pkg::OPC_BINARY) begin
                  bad = 1'b1;
                  code = wsfd_pkg::ERR_OPCODE;
               end
               if (bad) begin
                  stopped = 1'b1;
                  emit = 1'b1;
                  r.kind = wsfd_pkg::KIND_ERROR;
                  r.error_code = code;
               end else begin
                  taken = 0;
                  mask_word = '0;
                  if (b[6:0] == wsfd_pkg::LEN_EXT16) begin
                     frame_len = '0;
                     phase_q = TAKE_LEN16;
                  end else if (b[6:0] == wsfd_pkg::LEN_EXT64) begin
                     frame_len = '0;
                     phase_q = TAKE_LEN64;
                  end else begin
                     frame_len = 64'(b[6:0]);
                     phase_q = TAKE_KEY;
                  end
               end
            end
            TAKE_LEN16, TAKE_LEN64: begin
               frame_len = {frame_len[55:0], b};
               taken++;
               if (taken == ((phase_q == TAKE_LEN16) ? EXT16_LEN_BYTES : EXT64_LEN_BYTES)) begin
                  taken = 0;
                  phase_q = TAKE_KEY;
               end
            end
            TAKE_KEY: begin
               mask_word = {mask_word[23:0], b};
               taken++;
               if (taken == MASK_KEY_BYTES) begin
                  taken = 0;
                  key_pos = '0;
                  bytes_left = frame_len;
                  phase_q = (frame_len == 0) ? SEEK_FLAGS : TAKE_PAYLOAD;
                  emit = 1'b1;
                  r.kind = wsfd_pkg::KIND_HEADER;
                  r.payload_length = frame_len;
               end
            end
            TAKE_PAYLOAD: begin
               key = 8'(mask_word >> (24 - 8 * key_pos));
               emit = 1'b1;
               r.kind = wsfd_pkg::KIND_PAYLOAD;
               r.payload_length = frame_len;
               r.payload_byte = b ^ key;
               r.last_byte = (bytes_left <= 1);
               key_pos = key_pos + 2'd1;
               if (bytes_left <= 1) begin
                  bytes_left = '0;
                  phase_q = SEEK_FLAGS;
               end else begin
                  bytes_left = bytes_left - 1;
               end
            end
            default: phase_q = SEEK_FLAGS;
         endcase
      end
      if (emit) begin
         r.frame_opcode = opcode_cur;
         r.final_flag = fin_cur;
      end
      return emit;
   endfunction

   task automatic put_byte(input logic [7:0] value);
      stream_item_type item;
      item.value = value;
      item.drain = drain_next;
      drain_next = 1'b0;
      stream_bytes.push_back(item);
   endtask

   // Header, length in the requested encoding, key, then nbytes masked payload bytes.
   task automatic put_frame(input bit fin, input logic [3:0] op, input logic [63:0] len,
                            input int form, input logic [31:0] key,
                            input int unsigned nbytes);
      put_byte({fin, 3'b000, op});
      if (form == FORM_EXT16) begin
         put_byte({1'b1, wsfd_pkg::LEN_EXT16});
         put_byte(len[15:8]);
         put_byte(len[7:0]);
      end else if (form == FORM_EXT64) begin
         put_byte({1'b1, wsfd_pkg::LEN_EXT64});
         for (int i = 7; i >= 0; i--) put_byte(8'(len >> (8 * i)));
      end else begin
         put_byte({1'b1, len[6:0]});
      end
      for (int i = 3; i >= 0; i--) put_byte(8'(key >> (8 * i)));
      for (int unsigned i = 0; i < nbytes; i++) put_byte(8'($urandom_range(255)));
   endtask

   task automatic put_random_frame();
      int unsigned pick;
      logic [63:0] len;
      int form;
      logic [3:0] op;
      bit fin;
      pick = $urandom_range(99);
      if (pick < 20) begin
         case ($urandom_range(2))
            0:       op = wsfd_pkg::OPC_CLOSE;
            1:       op = wsfd_pkg::OPC_PING;
            default: op = wsfd_pkg::OPC_PONG;
         endcase
         fin = 1'b1;
         len = ($urandom_range(9) == 0) ? 64'($urandom_range(125)) : 64'($urandom_range(8));
         form = FORM_SHORT;
      end else begin
         case ($urandom_range(2))
            0:       op = OPC_CONT;
            1:       op = OPC_TEXT;
            default: op = wsfd_pkg::OPC_BINARY;
         endcase
         fin = 1'($urandom_range(1));
         pick = $urandom_range(99);
         if (pick < 65) len = 64'($urandom_range(16));
         else if (pick < 85) len = 64'($urandom_range(17, 125));
         else if (pick < 95) len = 64'($urandom_range(126, 400));
         else len = 64'($urandom_range(40));
         form = (len > 125) ? FORM_EXT16 : FORM_SHORT;
         // Longer encodings than needed are legal here and reach the extended paths.
         if (pick >= 95) form = $urandom_range(1) ? FORM_EXT16 : FORM_EXT64;
         else if (form == FORM_SHORT && $urandom_range(9) == 0) form = FORM_EXT16;
         else if (form == FORM_EXT16 && $urandom_range(3) == 0) form = FORM_EXT64;
      end
      put_frame(fin, op, len, form, $urandom(), len[31:0]);
   endtask

   // A header that the block must reject; the choice of bytes exercises check precedence.
   task automatic put_broken_frame(input logic [1:0] code);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [3:0] op;
      case ($urandom_range(2))
         0:       op = wsfd_pkg::OPC_CLOSE;
         1:       op = wsfd_pkg::OPC_PING;
         default: op = wsfd_pkg::OPC_PONG;
      endcase
      case (code)
         wsfd_pkg::ERR_NO_MASK: begin
            b0 = 8'($urandom_range(255));
            b1 = 8'($urandom_range(127));
         end
         wsfd_pkg::ERR_RSV: begin
            b0 = 8'($urandom_range(255));
            if (b0[6:4] == 3'd0) b0[4 + $urandom_range(2)] = 1'b1;
            b1 = 8'h80 | 8'($urandom_range(127));
         end
         wsfd_pkg::ERR_CONTROL: begin
            if ($urandom_range(1)) begin
               b0 = {1'b0, 3'b000, op};
               b1 = 8'h80 | 8'($urandom_range(127));
            end else begin
               b0 = {1'($urandom_range(1)), 3'b000, op};
               b1 = {1'b1, ($urandom_range(1) ? wsfd_pkg::LEN_EXT64 : wsfd_pkg::LEN_EXT16)};
            end
         end
         default: begin
            op = $urandom_range(1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
            b0 = {1'($urandom_range(1)), 3'b000, op};
            b1 = 8'h80 | 8'($urandom_range(127));
         end
      endcase
      put_byte(b0);
      put_byte(b1);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               what, results_seen, got, want);
      fail_count++;
   endtask

   task automatic check_result();
      wsfd_pkg::result_type want;
      results_seen++;
      if (parsed_results.size() == 0) begin
         report_mismatch("result with nothing pending, kind", 64'(rsp_kind), '0);
      end else begin
         want = parsed_results.pop_front();
         if (rsp_kind != want.kind)
            report_mismatch("kind", 64'(rsp_kind), 64'(want.kind));
         if (rsp_frame_opcode != want.frame_opcode)
            report_mismatch("frame_opcode", 64'(rsp_frame_opcode), 64'(want.frame_opcode));
         if (rsp_final_flag != want.final_flag)
            report_mismatch("final_flag", 64'(rsp_final_flag), 64'(want.final_flag));
         if (rsp_payload_length != want.payload_length)
            report_mismatch("payload_length", rsp_payload_length, want.payload_length);
         if (rsp_payload_byte != want.payload_byte)
            report_mismatch("payload_byte", 64'(rsp_payload_byte), 64'(want.payload_byte));
         if (rsp_last_byte != want.last_byte)
            report_mismatch("last_byte", 64'(rsp_last_byte), 64'(want.last_byte));
         if (rsp_error_code != want.error_code)
            report_mismatch("error_code", 64'(rsp_error_code), 64'(want.error_code));
         case (want.kind)
            wsfd_pkg::KIND_HEADER:  headers_seen++;
            wsfd_pkg::KIND_PAYLOAD: payloads_seen++;
            default:                errors_seen++;
         endcase
      end
   endtask

   // Sender: the prediction is made at the edge where a byte is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= '0;
         send_gap <= 0;
         clear_parser();
      end else begin
         offering = req_valid;
         if (req_valid && !req_stall) begin
            produced = parse_byte(req_rx_byte, predicted);
            if (produced) parsed_results.push_back(predicted);
            void'(stream_bytes.pop_front());
            bytes_sent++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (stream_bytes.size() != 0 &&
                         !(stream_bytes[0].drain && parsed_results.size() != 0)) begin
               req_valid <= 1'b1;
               req_rx_byte <= stream_bytes[0].value;
               send_gap <= idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus one long hold-off that backs the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         held <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!held && results_seen >= HOLD_AFTER) begin
            held <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            gap_draw = idle_len();
            rsp_stall <= (gap_draw != 0);
            stall_left <= (gap_draw != 0) ? gap_draw - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out with %0d results outstanding", parsed_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int unsigned base;
      bit          halt_tail;
      logic [63:0] huge_len;
      reset = 1'b1;
      drain_next = 1'b0;

      // Directed frames: length encodings at their edges, every opcode, key extremes.
      put_frame(1'b1, OPC_TEXT, 0, FORM_SHORT, 32'h0000_0000, 0);
      put_frame(1'b1, wsfd_pkg::OPC_BINARY, 1, FORM_SHORT, 32'hFFFF_FFFF, 1);
      put_frame(1'b0, OPC_TEXT, 3, FORM_SHORT, $urandom(), 3);
      put_frame(1'b0, OPC_CONT, 5, FORM_EXT16, $urandom(), 5);
      put_frame(1'b1, OPC_CONT, 4, FORM_EXT64, $urandom(), 4);
      put_frame(1'b1, wsfd_pkg::OPC_PING, 0, FORM_SHORT, $urandom(), 0);
      put_frame(1'b1, wsfd_pkg::OPC_PONG, 125, FORM_SHORT, $urandom(), 125);
      put_frame(1'b1, wsfd_pkg::OPC_CLOSE, 2, FORM_SHORT, $urandom(), 2);
      put_frame(1'b1, wsfd_pkg::OPC_BINARY, 126, FORM_EXT16, $urandom(), 126);
      put_frame(1'b1, wsfd_pkg::OPC_BINARY, 0, FORM_EXT16, $urandom(), 0);
      put_frame(1'b1, wsfd_pkg::OPC_BINARY, 0, FORM_EXT64, $urandom(), 0);
      put_frame(1'b1, OPC_TEXT, 9, FORM_SHORT, 32'h8040_2010, 9);
      put_frame(1'b1, wsfd_pkg::OPC_BINARY, 300, FORM_EXT16, $urandom(), 300);
      put_frame(1'b1, OPC_TEXT, 1, FORM_EXT64, $urandom(), 1);
      put_frame(1'b0, wsfd_pkg::OPC_BINARY, 125, FORM_SHORT, $urandom(), 125);

      // Random frames; now and then the sender waits for all results first.
      base = stream_bytes.size();
      drain_next = 1'b1;
      while (stream_bytes.size() - base < RANDOM_BYTES) begin
         if ($urandom_range(49) == 0) drain_next = 1'b1;
         put_random_frame();
      end

      // An error halts the block for good, so each run ends either with one rejected
      // header and ignored trailing bytes, or with a frame too long to finish.
      halt_tail = ($urandom_range(3) != 0);
      if (halt_tail) begin
         put_broken_frame(2'($urandom_range(3)));
         repeat (20) put_byte(8'($urandom_range(255)));
      end else begin
         huge_len = {32'($urandom()), 32'($urandom())};
         huge_len[63] = 1'($urandom_range(1));
         if (huge_len < 64) huge_len = huge_len + 64;
         put_frame(1'($urandom_range(1)), wsfd_pkg::OPC_BINARY, huge_len, FORM_EXT64,
                   $urandom(), 48);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (stream_bytes.size() != 0) @(posedge clock);
      while (parsed_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d stream bytes; checked %0d headers, %0d payload bytes, %0d errors.",
               bytes_sent, headers_seen, payloads_seen, errors_seen);
      $display("The stream ended with %s.",
               halt_tail ? "a rejected header and ignored bytes" : "an oversized frame");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
